// ===== design/dapec_pkg.sv =====
package dapec_pkg;

    localparam int WINDOW_SAMPLES_DEF = 16;
    localparam int ADC_FULL_SCALE_DEF = 4095;
    localparam int VREF_MILLIVOLT_DEF = 3300;

    localparam int SAMPLE_W      = 12;
    localparam int AVG_W         = 16;
    localparam int AVG_MAX       = 65520;
    localparam int OFFSET_W      = 15;
    localparam int FACTOR_W      = 16;
    localparam int PH_OUT_W      = 16;
    localparam int EC_OUT_W      = 18;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;

    localparam int PH_BASE_MILLI = 7000;
    localparam int PH_MID_MV     = 2500;
    localparam int PH_MIN        = -14000;
    localparam int PH_MAX        = 30000;
    localparam int EC_MAX        = 262143;
    localparam int EC_DIVISOR    = 1000;
    localparam int EC_FACTOR_RST = 820;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PH_OFFSET = 1'b0,
        REG_EC_FACTOR = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCUM,
        S_LOAD,
        S_DIV,
        S_CONV,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_PH_AVG,
        OP_EC_AVG,
        OP_PH_MV,
        OP_EC_MV,
        OP_EC
    } op_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] ph_sample;
        logic [SAMPLE_W-1:0] ec_sample;
    } sample_word_t;

    typedef struct packed {
        logic [AVG_W-1:0]           ph_average_raw;
        logic [AVG_W-1:0]           ec_average_raw;
        logic signed [PH_OUT_W-1:0] ph_milli;
        logic [EC_OUT_W-1:0]        ec_micro_siemens;
    } result_word_t;

endpackage

// ===== design/dapec_stream_if.sv =====
interface dapec_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dual_adc_average_ph_ec_convert.sv =====
// Moving average of paired pH and EC ADC samples over WINDOW_SAMPLES words, with
// conversion to milli-pH and uS/cm. One sample word is taken while ready is high;
// the block then drops ready until its result word has moved into the output
// register, where one finished word can wait while the next sample word is taken.
// All divisions run on one shared restoring divider that retires two quotient bits
// per cycle, and five of them are needed per word, one after another. A finished
// result word waits in the block while the output register is full.
// Until WINDOW_SAMPLES words have been seen, the averages divide by the word count.
// A write of zero to the EC factor register is ignored.
module dual_adc_average_ph_ec_convert #(
    parameter int WINDOW_SAMPLES = dapec_pkg::WINDOW_SAMPLES_DEF,
    parameter int ADC_FULL_SCALE = dapec_pkg::ADC_FULL_SCALE_DEF,
    parameter int VREF_MILLIVOLT = dapec_pkg::VREF_MILLIVOLT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dapec_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dapec_pkg::CFG_DATA_W-1:0] cfg_wdata,
    dapec_stream_if.sink                     samples,
    dapec_stream_if.source                   results
);
    import dapec_pkg::*;

    localparam int SLOT_W  = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
    localparam int FILL_W  = $clog2(WINDOW_SAMPLES + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_SAMPLES);
    localparam int MV_DEN  = ADC_FULL_SCALE * 16;
    localparam int MV_MAX  = (AVG_MAX * VREF_MILLIVOLT) / MV_DEN;
    localparam int MV_W    = $clog2(MV_MAX + 1);
    localparam int MUL_A_W = (MV_W > AVG_W) ? MV_W : AVG_W;
    localparam int MUL_B_W = FACTOR_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIV_W   = (SUM_W + 4 > PROD_W) ? SUM_W + 4 : PROD_W;
    localparam int DVS_A   = (FILL_W > 10) ? FILL_W : 10;
    localparam int DVS_B   = $clog2(MV_DEN + 1);
    localparam int DVS_W   = (DVS_A > DVS_B) ? DVS_A : DVS_B;
    localparam int RAM_W   = 2 * SAMPLE_W;

    state_t state_reg, state_next;
    op_t    op_reg;

    logic [SLOT_W-1:0]          slot_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic [SUM_W-1:0]           ph_sum_reg, ec_sum_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [FACTOR_W-1:0]        factor_reg;
    sample_word_t               in_reg;
    result_word_t               out_reg;
    logic                       out_valid_reg;
    logic [AVG_W-1:0]           ph_avg_reg, ec_avg_reg;
    logic [MV_W-1:0]            ph_mv_reg, ec_mv_reg;
    logic [EC_OUT_W-1:0]        ec_reg;

    logic                       in_accept, full, out_load;
    logic                       ram_we, div_start, div_busy;
    logic [RAM_W-1:0]           ram_rdata;
    sample_word_t               old_word;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PROD_W-1:0]          product;
    logic [DIV_W-1:0]           dividend, quotient;
    logic [DVS_W-1:0]           divisor;
    logic [EC_OUT_W-1:0]        ec_sat;
    logic signed [PH_OUT_W-1:0] ph_milli;

    assign in_accept = samples.valid && samples.ready;
    assign full      = fill_reg == FILL_W'(WINDOW_SAMPLES);
    assign old_word  = sample_word_t'(ram_rdata);

    dapec_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW_SAMPLES)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (RAM_W'(in_reg)),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        unique case (op_reg)
            OP_PH_MV: mul_a = MUL_A_W'(ph_avg_reg);
            OP_EC_MV: mul_a = MUL_A_W'(ec_avg_reg);
            default:  mul_a = MUL_A_W'(ec_mv_reg);
        endcase
        mul_b   = (op_reg == OP_EC) ? factor_reg : MUL_B_W'(VREF_MILLIVOLT);
        product = PROD_W'(mul_a) * PROD_W'(mul_b);
        unique case (op_reg)
            OP_PH_AVG:
            begin
                dividend = DIV_W'({ph_sum_reg, 4'b0000});
                divisor  = DVS_W'(fill_reg);
            end
            OP_EC_AVG:
            begin
                dividend = DIV_W'({ec_sum_reg, 4'b0000});
                divisor  = DVS_W'(fill_reg);
            end
            OP_PH_MV, OP_EC_MV:
            begin
                dividend = DIV_W'(product);
                divisor  = DVS_W'(MV_DEN);
            end
            default:
            begin
                dividend = DIV_W'(product);
                divisor  = DVS_W'(EC_DIVISOR);
            end
        endcase
    end

    dapec_divider #(
        .DIV_W (DIV_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign ec_sat = (quotient > DIV_W'(EC_MAX)) ? EC_OUT_W'(EC_MAX) : EC_OUT_W'(quotient);

    dapec_ph_calc #(
        .MV_W (MV_W)
    ) u_ph (
        .ph_mv    (ph_mv_reg),
        .offset   (offset_reg),
        .ph_milli (ph_milli)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_accept) state_next = S_ACCUM;
            S_ACCUM: state_next = S_LOAD;
            S_LOAD:  state_next = S_DIV;
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = (op_reg == OP_EC) ? S_CONV : S_LOAD;
                end
            end
            S_CONV:  state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || results.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        samples.ready = state_reg == S_IDLE;
        results.valid = out_valid_reg;
        ram_we        = state_reg == S_ACCUM;
        div_start     = state_reg == S_LOAD;
        out_load      = state_reg == S_OUT && (!out_valid_reg || results.ready);
    end

    assign results.data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_PH_AVG;
            slot_reg      <= '0;
            fill_reg      <= '0;
            ph_sum_reg    <= '0;
            ec_sum_reg    <= '0;
            offset_reg    <= '0;
            factor_reg    <= FACTOR_W'(EC_FACTOR_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_PH_OFFSET: offset_reg <= OFFSET_W'(cfg_wdata);
                    REG_EC_FACTOR:
                    begin
                        if (cfg_wdata != '0)
                        begin
                            factor_reg <= FACTOR_W'(cfg_wdata);
                        end
                    end
                endcase
            end
            if (state_reg == S_ACCUM)
            begin
                ph_sum_reg <= ph_sum_reg - (full ? SUM_W'(old_word.ph_sample) : '0)
                              + SUM_W'(in_reg.ph_sample);
                ec_sum_reg <= ec_sum_reg - (full ? SUM_W'(old_word.ec_sample) : '0)
                              + SUM_W'(in_reg.ec_sample);
                slot_reg   <= (slot_reg == SLOT_W'(WINDOW_SAMPLES - 1)) ? '0
                              : slot_reg + 1'b1;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                op_reg <= OP_PH_AVG;
            end
            else if (state_reg == S_DIV && !div_busy && op_reg != OP_EC)
            begin
                op_reg <= op_t'(op_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_reg <= samples.data;
        end
        if (state_reg == S_DIV && !div_busy)
        begin
            unique case (op_reg)
                OP_PH_AVG: ph_avg_reg <= AVG_W'(quotient);
                OP_EC_AVG: ec_avg_reg <= AVG_W'(quotient);
                OP_PH_MV:  ph_mv_reg  <= MV_W'(quotient);
                OP_EC_MV:  ec_mv_reg  <= MV_W'(quotient);
                default:   ec_reg     <= ec_sat;
            endcase
        end
        if (out_load)
        begin
            out_reg.ph_average_raw   <= ph_avg_reg;
            out_reg.ec_average_raw   <= ec_avg_reg;
            out_reg.ph_milli         <= ph_milli;
            out_reg.ec_micro_siemens <= ec_reg;
        end
    end

    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_DIV)
        else $error("divider busy outside the divide state");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |=> results.valid && $stable(results.data))
        else $error("result word dropped or changed while waiting");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_SAMPLES))
        else $error("fill count beyond window");

    a_accept_to_accum: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_ACCUM)
        else $error("accepted word not accumulated");
endmodule

// ===== design/dapec_ram.sv =====
module dapec_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/dapec_divider.sv =====
module dapec_divider #(
    parameter int DIV_W = 32,
    parameter int DVS_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);
    localparam int STEPS  = (DIV_W + 1) / 2;
    localparam int WORK_W = 2 * STEPS;
    localparam int CNT_W  = $clog2(STEPS + 1);

    logic [WORK_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [DVS_W:0]    rem_a, rem_b;
    logic [DVS_W-1:0]  rem_mid;
    logic              ge_a, ge_b;

    always_comb
    begin
        rem_a    = {rem_reg, quo_reg[WORK_W-1]};
        ge_a     = rem_a >= {1'b0, dvs_reg};
        rem_mid  = ge_a ? DVS_W'(rem_a - {1'b0, dvs_reg}) : DVS_W'(rem_a);
        rem_b    = {rem_mid, quo_reg[WORK_W-2]};
        ge_b     = rem_b >= {1'b0, dvs_reg};
        rem_next = ge_b ? DVS_W'(rem_b - {1'b0, dvs_reg}) : DVS_W'(rem_b);
        quo_next = {quo_reg[WORK_W-3:0], ge_a, ge_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= WORK_W'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[DIV_W-1:0];
endmodule

// ===== design/dapec_ph_calc.sv =====
module dapec_ph_calc #(
    parameter int MV_W = 12
) (
    input  logic [MV_W-1:0]  ph_mv,
    input  logic signed [14:0] offset,
    output logic signed [15:0] ph_milli
);
    import dapec_pkg::*;

    localparam int D_W  = ((MV_W > 12) ? MV_W : 12) + 1;
    localparam int PH_W = D_W + 4;

    logic signed [D_W-1:0]  diff;
    logic signed [D_W+2:0]  times7;
    logic signed [D_W+2:0]  adj;
    logic signed [D_W+1:0]  half;
    logic signed [PH_W-1:0] total;

    always_comb
    begin
        diff   = $signed(D_W'(PH_MID_MV)) - $signed(D_W'(ph_mv));
        times7 = ((D_W + 3)'(diff) <<< 3) - (D_W + 3)'(diff);
        adj    = times7 + $signed((D_W + 3)'(times7[D_W+2]));
        half   = (D_W + 2)'(adj >>> 1);
        total  = PH_W'(PH_BASE_MILLI) + PH_W'(half) + PH_W'(offset);
        priority if (total < PH_W'(PH_MIN))
        begin
            ph_milli = PH_OUT_W'(PH_MIN);
        end
        else if (total > PH_W'(PH_MAX))
        begin
            ph_milli = PH_OUT_W'(PH_MAX);
        end
        else
        begin
            ph_milli = PH_OUT_W'(total);
        end
    end
endmodule
